@@ hdl/u2u_pkg.sv @@
package u2u_pkg;

  localparam int CpWidth    = 21;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int CfgIdxW    = 1;

  localparam logic [15:0]        Repl     = 16'hFFFD;
  localparam logic [15:0]        HiBase   = 16'hD800;
  localparam logic [15:0]        LoBase   = 16'hDC00;
  localparam logic [15:0]        CountMax = 16'hFFFF;
  localparam logic [CpWidth-1:0] SuppBase = 21'h10000;

  localparam logic [CfgIdxW-1:0] RegCodePage  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegRoomLimit = 1'b1;

  localparam logic CodePageLatin1 = 1'b0;
  localparam logic CodePageUtf8   = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } byte_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic [15:0] unit_count;
    logic        overflow;
    logic        run_last;
    logic        string_end;
  } unit_item_t;

  // Decoded work for one byte: repl_cnt replacement points, then an optional tail point.
  typedef struct packed {
    logic [1:0]         repl_cnt;
    logic               tail_en;
    logic [CpWidth-1:0] tail_cp;
    logic               last;
  } job_t;

endpackage

@@ hdl/u2u_front.sv @@
module u2u_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                code_page,
  input  logic                accept,
  input  u2u_pkg::byte_item_t item,
  output u2u_pkg::job_t       job,
  output logic                push
);

  logic [2:0]                    seq_len, seq_len_next;
  logic [1:0]                    coll, coll_next;
  logic [u2u_pkg::CpWidth-1:0]   part, part_next;

  logic [7:0]                    b;
  logic                          lead2, lead3, lead4;
  logic                          dn_tail_en;
  logic [u2u_pkg::CpWidth-1:0]   dn_tail_cp;
  logic                          dn_start;
  logic [2:0]                    dn_len;
  logic [u2u_pkg::CpWidth-1:0]   dn_bits;
  logic [1:0]                    nc;
  logic [u2u_pkg::CpWidth-1:0]   cont_code;

  assign b     = item.in_byte;
  assign lead2 = (b[7:5] == 3'b110);
  assign lead3 = (b[7:4] == 4'b1110);
  assign lead4 = (b[7:3] == 5'b11110);
  assign nc        = coll + 2'd1;
  assign cont_code = {part[u2u_pkg::CpWidth-7:0], b[5:0]};

  // classify a byte with no sequence pending
  always_comb begin
    dn_tail_en = 1'b0;
    dn_tail_cp = '0;
    dn_start   = 1'b0;
    dn_len     = 3'd0;
    dn_bits    = '0;
    if (!b[7]) begin
      dn_tail_en = 1'b1;
      dn_tail_cp = u2u_pkg::CpWidth'(b);
    end else if ((lead2 || lead3 || lead4) && !item.in_last) begin
      dn_start = 1'b1;
      priority if (lead2) begin
        dn_len  = 3'd2;
        dn_bits = u2u_pkg::CpWidth'(b[4:0]);
      end else if (lead3) begin
        dn_len  = 3'd3;
        dn_bits = u2u_pkg::CpWidth'(b[3:0]);
      end else begin
        dn_len  = 3'd4;
        dn_bits = u2u_pkg::CpWidth'(b[2:0]);
      end
    end else begin
      dn_tail_en = 1'b1;
      dn_tail_cp = u2u_pkg::CpWidth'(u2u_pkg::Repl);
    end
  end

  always_comb begin
    job          = '0;
    job.last     = item.in_last;
    seq_len_next = seq_len;
    coll_next    = coll;
    part_next    = part;
    if (code_page == u2u_pkg::CodePageLatin1) begin
      seq_len_next = 3'd0;
      coll_next    = 2'd0;
      part_next    = '0;
      job.tail_en  = 1'b1;
      job.tail_cp  = u2u_pkg::CpWidth'(b);
    end else if (seq_len != 3'd0) begin
      if (b[7:6] == 2'b10) begin
        if (({1'b0, nc} + 3'd1) >= seq_len) begin
          job.tail_en  = 1'b1;
          job.tail_cp  = cont_code;
          seq_len_next = 3'd0;
          coll_next    = 2'd0;
          part_next    = '0;
        end else if (item.in_last) begin
          job.repl_cnt = nc + 2'd1;
          seq_len_next = 3'd0;
          coll_next    = 2'd0;
          part_next    = '0;
        end else begin
          coll_next = nc;
          part_next = cont_code;
        end
      end else begin
        job.repl_cnt = nc;
        job.tail_en  = dn_tail_en;
        job.tail_cp  = dn_tail_cp;
        if (dn_start) begin
          seq_len_next = dn_len;
          coll_next    = 2'd0;
          part_next    = dn_bits;
        end else begin
          seq_len_next = 3'd0;
          coll_next    = 2'd0;
          part_next    = '0;
        end
      end
    end else begin
      job.tail_en = dn_tail_en;
      job.tail_cp = dn_tail_cp;
      if (dn_start) begin
        seq_len_next = dn_len;
        coll_next    = 2'd0;
        part_next    = dn_bits;
      end
    end
    if (item.in_last) begin
      seq_len_next = 3'd0;
      coll_next    = 2'd0;
      part_next    = '0;
    end
  end

  assign push = accept && ((job.repl_cnt != 2'd0) || job.tail_en);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len <= 3'd0;
      coll    <= 2'd0;
      part    <= '0;
    end else if (accept) begin
      seq_len <= seq_len_next;
      coll    <= coll_next;
      part    <= part_next;
    end
  end

endmodule

@@ hdl/u2u_queue.sv @@
module u2u_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  u2u_pkg::job_t wr_job,
  input  logic          pop,
  output u2u_pkg::job_t head,
  output logic          head_valid,
  output logic          full
);

  u2u_pkg::job_t                entries [u2u_pkg::QueueDepth];
  logic [u2u_pkg::QPtrW-1:0]    wr_ptr, rd_ptr;
  logic [u2u_pkg::QPtrW:0]      count;

  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == (u2u_pkg::QPtrW+1)'(u2u_pkg::QueueDepth));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + u2u_pkg::QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + u2u_pkg::QPtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (u2u_pkg::QPtrW+1)'(1);
        2'b01:   count <= count - (u2u_pkg::QPtrW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/u2u_back.sv @@
module u2u_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         room_limit,
  input  u2u_pkg::job_t       head,
  input  logic                head_valid,
  output logic                pop,
  output logic                unit_valid,
  input  logic                unit_ready,
  output u2u_pkg::unit_item_t unit_data
);

  logic [1:0]                   rep_done, rep_done_next;
  logic                         low_pend, low_pend_next;
  logic [15:0]                  units, units_next;
  logic                         dropping, dropping_next;

  logic                         advance;
  logic                         tail_point;
  logic                         final_point;
  logic [u2u_pkg::CpWidth-1:0]  cur_cp;
  logic [u2u_pkg::CpWidth-1:0]  v;
  logic                         big;
  logic [16:0]                  need_total;
  logic                         over;
  logic [15:0]                  units_inc;
  logic                         emit;
  u2u_pkg::unit_item_t          emit_data;

  assign advance     = head_valid && (!unit_valid || unit_ready);
  assign tail_point  = (rep_done == head.repl_cnt);
  assign cur_cp      = tail_point ? head.tail_cp : u2u_pkg::CpWidth'(u2u_pkg::Repl);
  assign final_point = tail_point ||
                       (!head.tail_en && (rep_done == (head.repl_cnt - 2'd1)));
  assign big         = (cur_cp[u2u_pkg::CpWidth-1:16] != '0);
  assign v           = cur_cp - u2u_pkg::SuppBase;
  assign need_total  = {1'b0, units} + (big ? 17'd2 : 17'd1);
  assign over        = (room_limit != 16'd0) && (need_total > {1'b0, room_limit});
  assign units_inc   = (units != u2u_pkg::CountMax) ? (units + 16'd1) : units;

  always_comb begin
    pop            = 1'b0;
    emit           = 1'b0;
    emit_data      = '0;
    rep_done_next  = rep_done;
    low_pend_next  = low_pend;
    units_next     = units;
    dropping_next  = dropping;
    if (advance) begin
      if (dropping) begin
        pop = 1'b1;
      end else if (low_pend) begin
        emit                 = 1'b1;
        emit_data.code_unit  = u2u_pkg::LoBase + 16'(v[9:0]);
        emit_data.unit_count = units_inc;
        emit_data.run_last   = 1'b1;
        units_next           = units_inc;
        pop                  = 1'b1;
      end else if (over) begin
        emit                 = 1'b1;
        emit_data.unit_count = units;
        emit_data.overflow   = 1'b1;
        emit_data.run_last   = 1'b1;
        dropping_next        = 1'b1;
        pop                  = 1'b1;
      end else if (big) begin
        emit                 = 1'b1;
        emit_data.code_unit  = u2u_pkg::HiBase + 16'(v[u2u_pkg::CpWidth-1:10]);
        emit_data.unit_count = units_inc;
        units_next           = units_inc;
        low_pend_next        = 1'b1;
      end else begin
        emit                 = 1'b1;
        emit_data.code_unit  = cur_cp[15:0];
        emit_data.unit_count = units_inc;
        units_next           = units_inc;
        if (final_point) begin
          emit_data.run_last = 1'b1;
          pop                = 1'b1;
        end else begin
          rep_done_next = rep_done + 2'd1;
        end
      end
      emit_data.string_end = emit_data.run_last && head.last;
      if (pop) begin
        rep_done_next = 2'd0;
        low_pend_next = 1'b0;
        if (head.last) begin
          units_next    = 16'd0;
          dropping_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_done   <= 2'd0;
      low_pend   <= 1'b0;
      units      <= 16'd0;
      dropping   <= 1'b0;
      unit_valid <= 1'b0;
    end else begin
      rep_done <= rep_done_next;
      low_pend <= low_pend_next;
      units    <= units_next;
      dropping <= dropping_next;
      if (emit) begin
        unit_valid <= 1'b1;
      end else if (unit_ready) begin
        unit_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      unit_data <= emit_data;
    end
  end

endmodule

@@ hdl/utf8_to_utf16_decoder_core.sv @@
// UTF-8 or Latin-1 byte stream to UTF-16 code units. A byte is taken on every cycle while
// the four-entry job queue between the byte classifier and the unit emitter has room. The
// emitter gives one code unit per cycle unless unit_ready stalls it; a byte that yields up
// to four units (held replacements, a new point or a surrogate pair) keeps it busy for each,
// and a byte that only extends a sequence costs none. A byte's job enters the queue on its
// transfer and its units are then registered at the output. Reset sets code_page to UTF-8
// and room_limit to 0 (no limit); write configuration only while the block is idle.
module utf8_to_utf16_decoder_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          byte_valid,
  output logic                          byte_ready,
  input  u2u_pkg::byte_item_t           byte_data,
  output logic                          unit_valid,
  input  logic                          unit_ready,
  output u2u_pkg::unit_item_t           unit_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [u2u_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [15:0]                   cfg_data
);

  logic           code_page;
  logic [15:0]    room_limit;
  logic           accept;
  logic           push;
  logic           pop;
  logic           full;
  logic           head_valid;
  u2u_pkg::job_t  new_job;
  u2u_pkg::job_t  head;

  assign cfg_ready  = 1'b1;
  assign byte_ready = !full;
  assign accept     = byte_valid && byte_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_page  <= u2u_pkg::CodePageUtf8;
      room_limit <= 16'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        u2u_pkg::RegCodePage:  code_page  <= cfg_data[0];
        u2u_pkg::RegRoomLimit: room_limit <= cfg_data;
      endcase
    end
  end

  u2u_front u_front (
    .clk       (clk),
    .rst       (rst),
    .code_page (code_page),
    .accept    (accept),
    .item      (byte_data),
    .job       (new_job),
    .push      (push)
  );

  u2u_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_job     (new_job),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  u2u_back u_back (
    .clk        (clk),
    .rst        (rst),
    .room_limit (room_limit),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .unit_valid (unit_valid),
    .unit_ready (unit_ready),
    .unit_data  (unit_data)
  );

endmodule

@@ bench/tb_utf8_to_utf16_decoder_core.sv @@
`timescale 1ns / 100ps

module tb_utf8_to_utf16_decoder_core;

  localparam int CycleLimit   = 1_000_000;
  localparam int SettleCycles = 16;
  localparam int PhaseBytes   = 24;

  class unit_scoreboard;
    logic                 cp;
    logic [15:0]          limit;
    logic [2:0]           seq_len;
    logic [1:0]           held;
    logic [20:0]          acc;
    logic [15:0]          count;
    logic                 drop;
    u2u_pkg::unit_item_t  exp_q[$];
    u2u_pkg::unit_item_t  run[$];
    int                   errors;
    int                   checked;
    int                   ovf_seen;
    int                   strings;

    function new();
      cp       = u2u_pkg::CodePageUtf8;
      limit    = '0;
      seq_len  = '0;
      held     = '0;
      acc      = '0;
      count    = '0;
      drop     = 1'b0;
      errors   = 0;
      checked  = 0;
      ovf_seen = 0;
      strings  = 0;
    endfunction

    function void write_reg(logic [u2u_pkg::CfgIdxW-1:0] idx, logic [15:0] val);
      if (idx == u2u_pkg::RegCodePage) begin
        cp = val[0];
      end else if (idx == u2u_pkg::RegRoomLimit) begin
        limit = val;
      end
    endfunction

    function int pending();
      return exp_q.size();
    endfunction

    function void push_point(logic [20:0] pt);
      int                   need;
      logic [20:0]          v;
      u2u_pkg::unit_item_t  u;
      if (drop) return;
      need = (pt >= u2u_pkg::SuppBase) ? 2 : 1;
      u = '0;
      if (limit != 0 && int'(count) + need > int'(limit)) begin
        u.unit_count = count;
        u.overflow   = 1'b1;
        run.push_back(u);
        drop = 1'b1;
        return;
      end
      v = pt - u2u_pkg::SuppBase;
      for (int k = 0; k < need; k++) begin
        if (need == 2) begin
          u.code_unit = (k == 0) ? u2u_pkg::HiBase + 16'(v >> 10) :
                                   u2u_pkg::LoBase + 16'(v[9:0]);
        end else begin
          u.code_unit = pt[15:0];
        end
        if (count != u2u_pkg::CountMax) count++;
        u.unit_count = count;
        run.push_back(u);
      end
    endfunction

    function void flush_held();
      for (int k = 0; k <= int'(held); k++) push_point(21'(u2u_pkg::Repl));
      seq_len = '0;
      held    = '0;
      acc     = '0;
    endfunction

    function void start_point(logic [7:0] b, logic l);
      logic [2:0]  len;
      logic [20:0] bits;
      len  = '0;
      bits = '0;
      if (b < 8'h80) begin
        push_point(21'(b));
        return;
      end
      if ((b & 8'hE0) == 8'hC0) begin
        len  = 3'd2;
        bits = 21'(b & 8'h1F);
      end else if ((b & 8'hF0) == 8'hE0) begin
        len  = 3'd3;
        bits = 21'(b & 8'h0F);
      end else if ((b & 8'hF8) == 8'hF0) begin
        len  = 3'd4;
        bits = 21'(b & 8'h07);
      end
      if (len == 0 || l) begin
        push_point(21'(u2u_pkg::Repl));
        return;
      end
      seq_len = len;
      held    = '0;
      acc     = bits;
    endfunction

    function void note_byte(u2u_pkg::byte_item_t it);
      logic [20:0] pt;
      run.delete();
      if (!drop) begin
        if (cp == u2u_pkg::CodePageLatin1) begin
          seq_len = '0;
          held    = '0;
          acc     = '0;
          push_point(21'(it.in_byte));
        end else if (seq_len != 0) begin
          if ((it.in_byte & 8'hC0) == 8'h80) begin
            acc  = {acc[14:0], it.in_byte[5:0]};
            held = held + 2'd1;
            if (int'(held) + 1 >= int'(seq_len)) begin
              pt      = acc;
              seq_len = '0;
              held    = '0;
              acc     = '0;
              push_point(pt);
            end else if (it.in_last) begin
              flush_held();
            end
          end else begin
            flush_held();
            start_point(it.in_byte, it.in_last);
          end
        end else begin
          start_point(it.in_byte, it.in_last);
        end
      end
      if (run.size() > 0) begin
        run[run.size()-1].run_last   = 1'b1;
        run[run.size()-1].string_end = it.in_last;
      end
      foreach (run[i]) exp_q.push_back(run[i]);
      if (it.in_last) begin
        seq_len = '0;
        held    = '0;
        acc     = '0;
        count   = '0;
        drop    = 1'b0;
        strings++;
      end
    endfunction

    function void check_unit(u2u_pkg::unit_item_t got);
      u2u_pkg::unit_item_t want;
      checked++;
      if (got.overflow) ovf_seen++;
      if (exp_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected unit: unit %h count %h ovf %b run_last %b end %b",
                   got.code_unit, got.unit_count, got.overflow, got.run_last,
                   got.string_end);
        end
        return;
      end
      want = exp_q.pop_front();
      if (got.code_unit !== want.code_unit || got.unit_count !== want.unit_count ||
          got.overflow !== want.overflow || got.run_last !== want.run_last ||
          got.string_end !== want.string_end) begin
        errors++;
        if (errors <= 10) begin
          $display("unit mismatch: expected unit %h count %h ovf %b run_last %b end %b",
                   want.code_unit, want.unit_count, want.overflow, want.run_last,
                   want.string_end);
          $display("               actual   unit %h count %h ovf %b run_last %b end %b",
                   got.code_unit, got.unit_count, got.overflow, got.run_last,
                   got.string_end);
        end
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          byte_valid;
  logic                          byte_ready;
  u2u_pkg::byte_item_t           byte_data;
  logic                          unit_valid;
  logic                          unit_ready;
  u2u_pkg::unit_item_t           unit_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [u2u_pkg::CfgIdxW-1:0]   cfg_index;
  logic [15:0]                   cfg_data;

  unit_scoreboard sb;
  bit             tx_gaps;
  bit             rx_stalls;
  int             n_sent;
  int             cycles;
  logic [7:0]     str_q[$];

  utf8_to_utf16_decoder_core u_top (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .unit_valid (unit_valid),
    .unit_ready (unit_ready),
    .unit_data  (unit_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && byte_valid && byte_ready) sb.note_byte(byte_data);
    if (!rst && unit_valid && unit_ready) sb.check_unit(unit_data);
  end

  initial begin
    unit_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_stalls && $urandom_range(0, 5) == 0) begin
        unit_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      unit_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    byte_data  <= {b, l};
    byte_valid <= 1'b1;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    n_sent++;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_str();
    foreach (str_q[i]) send_byte(str_q[i], i == str_q.size() - 1);
  endtask

  // drain expected units, then give the block time to retire result-free bytes
  task automatic settle();
    byte_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic configure(input logic cp, input logic [15:0] lim);
    cfg_index <= u2u_pkg::RegCodePage;
    cfg_data  <= 16'(cp);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(u2u_pkg::RegCodePage, 16'(cp));
    cfg_index <= u2u_pkg::RegRoomLimit;
    cfg_data  <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(u2u_pkg::RegRoomLimit, lim);
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_random();
    str_q.delete();
    repeat ($urandom_range(1, 12)) str_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_cont(input int n);
    repeat (n) str_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
  endtask

  // mostly well-formed UTF-8 with random content, some stray and truncated bytes
  task automatic fill_utf8();
    int len;
    str_q.delete();
    repeat ($urandom_range(1, 10)) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: str_q.push_back(8'($urandom_range(0, 127)));
        6, 7, 8, 9: begin
          str_q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
          add_cont(1);
        end
        10, 11, 12: begin
          str_q.push_back(8'hE0 | 8'($urandom_range(0, 15)));
          add_cont(2);
        end
        13, 14, 15: begin
          str_q.push_back(8'hF0 | 8'($urandom_range(0, 7)));
          add_cont(3);
        end
        16: add_cont(1);
        17: str_q.push_back(8'($urandom_range(248, 255)));
        18: begin
          len = $urandom_range(2, 4);
          str_q.push_back((len == 2) ? 8'hC2 : (len == 3) ? 8'hE3 : 8'hF1);
          add_cont($urandom_range(0, len - 2));
        end
        default: str_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic run_phase(input logic cp, input logic [15:0] lim, input bit gaps);
    int start;
    settle();
    configure(cp, lim);
    tx_gaps   = gaps;
    rx_stalls = gaps;
    start     = n_sent;
    while (n_sent - start < PhaseBytes) begin
      if ($urandom_range(0, 3) == 0) fill_random();
      else fill_utf8();
      send_str();
    end
  endtask

  initial begin
    sb         = new();
    n_sent     = 0;
    cycles     = 0;
    tx_gaps    = 1'b1;
    rx_stalls  = 1'b1;
    rst        <= 1'b1;
    byte_valid <= 1'b0;
    byte_data  <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    settle();
    configure(u2u_pkg::CodePageUtf8, 16'd0);
    str_q = '{8'h00, 8'h7F, 8'hE2, 8'h82, 8'hAC, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hC0,
              8'h80, 8'hBF, 8'hF0, 8'h9F, 8'h98, 8'hFF, 8'hE2, 8'h82, 8'h41, 8'hE2,
              8'h82};
    send_str();
    send_byte(8'hC2, 1'b1);

    settle();
    configure(u2u_pkg::CodePageUtf8, 16'd2);
    str_q = '{8'h41, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h42};
    send_str();

    settle();
    configure(u2u_pkg::CodePageUtf8, 16'd0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    settle();
    configure(u2u_pkg::CodePageLatin1, 16'd0);
    send_byte(8'hFF, 1'b1);

    run_phase(u2u_pkg::CodePageUtf8, 16'd0, 1'b1);
    run_phase(u2u_pkg::CodePageUtf8, 16'($urandom_range(1, 8)), 1'b1);
    run_phase(u2u_pkg::CodePageLatin1, 16'd0, 1'b1);
    run_phase(u2u_pkg::CodePageLatin1, 16'($urandom_range(1, 6)), 1'b1);
    run_phase(u2u_pkg::CodePageUtf8, 16'hFFFF, 1'b1);
    run_phase(u2u_pkg::CodePageUtf8, 16'd0, 1'b0);

    settle();
    $display("Covered %0d bytes in %0d strings over both code pages, room limits 0 to 65535",
             n_sent, sb.strings);
    $display("Checked %0d code units, %0d of them overflow results", sb.checked, sb.ovf_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
